FILE: rtl/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

    localparam int DIMENSIONS_DEF  = 3;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int NUM_AXES       = 3;
    localparam int BOX_FIELDS     = 2 * NUM_AXES;
    localparam int IN_FIELDS      = 2 * BOX_FIELDS;
    localparam int MAX_PIECES     = 2 * NUM_AXES;

    localparam logic [MAX_PIECES-1:0] FIRST_ONLY = {{(MAX_PIECES-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        OUTCOME_PIECE    = 2'd0,
        OUTCOME_COVERED  = 2'd1,
        OUTCOME_DISJOINT = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [MAX_PIECES-1:0] mask;
        outcome_t              outcome;
    } piece_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/bsd_dissect.sv
`default_nettype none

module bsd_dissect
    import bsd_pkg::*;
#(
    parameter int DIMENSIONS  = DIMENSIONS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic [IN_FIELDS*COORD_WIDTH-1:0]  request,
    output logic [BOX_FIELDS*COORD_WIDTH-1:0] piece [MAX_PIECES],
    output piece_ctrl_t                       ctrl
);

    logic signed [COORD_WIDTH-1:0] ql [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] qh [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] fl [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] fh [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] cl [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] ch [NUM_AXES];
    logic [NUM_AXES-1:0]           left_cut;
    logic [NUM_AXES-1:0]           right_cut;
    logic [NUM_AXES-1:0]           cov;
    logic [NUM_AXES-1:0]           touch;
    logic [MAX_PIECES-1:0]         mask;

    always_comb
    begin
        for (int d = 0; d < NUM_AXES; d++)
        begin
            ql[d] = request[(2*d)*COORD_WIDTH +: COORD_WIDTH];
            qh[d] = request[(2*d+1)*COORD_WIDTH +: COORD_WIDTH];
            fl[d] = request[(BOX_FIELDS+2*d)*COORD_WIDTH +: COORD_WIDTH];
            fh[d] = request[(BOX_FIELDS+2*d+1)*COORD_WIDTH +: COORD_WIDTH];
            if (d < DIMENSIONS)
            begin
                left_cut[d]  = fl[d] > ql[d];
                right_cut[d] = fh[d] < qh[d];
                cov[d]       = (fl[d] <= ql[d]) && (fh[d] >= qh[d]);
                touch[d]     = (ql[d] <= fh[d]) && (qh[d] >= fl[d]);
            end
            else
            begin
                left_cut[d]  = 1'b0;
                right_cut[d] = 1'b0;
                cov[d]       = 1'b1;
                touch[d]     = 1'b1;
            end
            cl[d] = left_cut[d] ? fl[d] : ql[d];
            ch[d] = right_cut[d] ? fh[d] : qh[d];
        end
    end

    // Slab 2d is the left slab of axis d and slab 2d+1 the right one.
    // Axes already worked are clipped to the fill range.
    always_comb
    begin
        for (int d = 0; d < NUM_AXES; d++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                mask[2*d+s] = (s == 0) ? left_cut[d] : right_cut[d];
                for (int e = 0; e < NUM_AXES; e++)
                begin
                    if (e >= DIMENSIONS)
                    begin
                        piece[2*d+s][(2*e)*COORD_WIDTH +: COORD_WIDTH]   = '0;
                        piece[2*d+s][(2*e+1)*COORD_WIDTH +: COORD_WIDTH] = '0;
                    end
                    else if (e < d)
                    begin
                        piece[2*d+s][(2*e)*COORD_WIDTH +: COORD_WIDTH]   = cl[e];
                        piece[2*d+s][(2*e+1)*COORD_WIDTH +: COORD_WIDTH] = ch[e];
                    end
                    else if (e == d)
                    begin
                        piece[2*d+s][(2*e)*COORD_WIDTH +: COORD_WIDTH]   =
                            (s == 0) ? ql[e] : fh[e];
                        piece[2*d+s][(2*e+1)*COORD_WIDTH +: COORD_WIDTH] =
                            (s == 0) ? fl[e] : qh[e];
                    end
                    else
                    begin
                        piece[2*d+s][(2*e)*COORD_WIDTH +: COORD_WIDTH]   = ql[e];
                        piece[2*d+s][(2*e+1)*COORD_WIDTH +: COORD_WIDTH] = qh[e];
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (&cov)
        begin
            ctrl.mask    = FIRST_ONLY;
            ctrl.outcome = OUTCOME_COVERED;
        end
        else if (!(&touch))
        begin
            ctrl.mask    = FIRST_ONLY;
            ctrl.outcome = OUTCOME_DISJOINT;
        end
        else if (mask == '0)
        begin
            ctrl.mask    = FIRST_ONLY;
            ctrl.outcome = OUTCOME_COVERED;
        end
        else
        begin
            ctrl.mask    = mask;
            ctrl.outcome = OUTCOME_PIECE;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bsd_serializer.sv
`default_nettype none

module bsd_serializer
    import bsd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [BOX_FIELDS*COORD_WIDTH-1:0] piece [MAX_PIECES],
    input  piece_ctrl_t                       ctrl,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [BOX_FIELDS*COORD_WIDTH-1:0] out_piece,
    output outcome_t                          out_outcome,
    output logic                              out_last
);

    localparam int PW = BOX_FIELDS * COORD_WIDTH;

    logic [MAX_PIECES-1:0] pending_reg;
    logic [MAX_PIECES-1:0] pending_next;
    outcome_t              outcome_reg;
    logic [PW-1:0]         piece_reg [MAX_PIECES];
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PW-1:0]         out_piece_reg;
    outcome_t              out_outcome_reg;
    logic                  out_last_reg;

    logic [MAX_PIECES-1:0] sel;
    logic [MAX_PIECES-1:0] remaining;
    logic [PW-1:0]         picked;
    logic                  out_free;
    logic                  move;
    logic                  load;

    always_comb
    begin
        sel       = pending_reg & (~pending_reg + 1'b1);
        remaining = pending_reg & ~sel;
        picked    = '0;
        for (int i = 0; i < MAX_PIECES; i++)
        begin
            picked = picked | (piece_reg[i] & {PW{sel[i]}});
        end
        out_free = !out_valid_reg || out_ready;
        move     = (pending_reg != '0) && out_free;
        in_ready = (pending_reg == '0) || (move && (remaining == '0));
        load     = in_valid && in_ready;

        if (load)
        begin
            pending_next = ctrl.mask;
        end
        else if (move)
        begin
            pending_next = remaining;
        end
        else
        begin
            pending_next = pending_reg;
        end

        if (out_free)
        begin
            out_valid_next = pending_reg != '0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            piece_reg   <= piece;
            outcome_reg <= ctrl.outcome;
        end
        if (move)
        begin
            // Covered and disjoint results carry no box.
            out_piece_reg   <= (outcome_reg == OUTCOME_PIECE) ? picked : '0;
            out_outcome_reg <= outcome_reg;
            out_last_reg    <= remaining == '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_piece   = out_piece_reg;
    assign out_outcome = out_outcome_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/box_subtract_dissect.sv
// Box difference: each request on the s_axis channel carries a query box and a
// fill box, and the m_axis channel returns the axis-aligned pieces that cover
// the part of the query box outside the fill box, left then right slab on
// each axis, x first. A request whose query box lies inside the fill box
// returns one result marked covered, and one whose boxes do not meet returns
// one result marked disjoint; both carry zero bounds. tlast marks the final
// result of each request.
// After a request is accepted it passes through the input register and the
// piece buffer, and its results leave through the output register. The output
// register sends one result per cycle while m_axis_tready is high; a request
// has one to six results, and the next request is taken into the input
// register meanwhile and its pieces enter the buffer in the cycle the last piece
// of the previous one moves out. When m_axis_tready is low, results hold and
// s_axis_tready drops once the input register and the buffer are both full.
// Reset empties all stages and discards pending results.
`default_nettype none

module box_subtract_dissect
    import bsd_pkg::*;
#(
    parameter int DIMENSIONS  = DIMENSIONS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_W       = IN_FIELDS * COORD_WIDTH,
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = BOX_FIELDS * COORD_WIDTH,
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // box_x_low, box_x_high, box_y_low, box_y_high, box_z_low, box_z_high,
    // fill_x_low, fill_x_high, fill_y_low, fill_y_high, fill_z_low, fill_z_high
    input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // piece_x_low, piece_x_high, piece_y_low, piece_y_high, piece_z_low, piece_z_high
    output logic [OUT_BYTES_W-1:0] m_axis_tdata,
    // outcome
    output logic [1:0]             m_axis_tuser,
    // last_piece
    output logic                   m_axis_tlast
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [IN_W-1:0]    request_reg;
    logic               s_accept;
    logic               buf_ready;
    logic [OUT_W-1:0]   piece [MAX_PIECES];
    piece_ctrl_t        ctrl;
    logic [OUT_W-1:0]   out_piece;
    outcome_t           out_outcome;

    assign s_axis_tready = !in_valid_reg || buf_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !buf_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            request_reg <= s_axis_tdata[IN_W-1:0];
        end
    end

    bsd_dissect #(
        .DIMENSIONS  (DIMENSIONS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dissect (
        .request (request_reg),
        .piece   (piece),
        .ctrl    (ctrl)
    );

    bsd_serializer #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid_reg),
        .in_ready    (buf_ready),
        .piece       (piece),
        .ctrl        (ctrl),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_piece   (out_piece),
        .out_outcome (out_outcome),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_BYTES_W'(out_piece);
    assign m_axis_tuser = out_outcome;

endmodule

`default_nettype wire
